FILE: src/rdm_pkg.sv
// ----------------------------------------------------------------------------
// rdm_pkg
// Shared types and constants of the radial distortion map generator.
// ----------------------------------------------------------------------------
package rdm_pkg;

  localparam int MaxDim      = 8192;
  localparam int OutFracBits = 8;

  localparam int SideW  = 14;              // register width of an image side
  localparam int CoordW = 13;              // pixel index width
  localparam int OffW   = CoordW + 3;      // signed half-pixel offset from the centre
  localparam int R2W    = 2 * (OffW - 1) + 1;
  localparam int SqFrac = 28;              // r2 is scaled by 2^28 before the root
  localparam int SqW    = (R2W + SqFrac + 1) / 2;
  localparam int SqInW  = 2 * SqW;
  localparam int RemW   = SqW + 3;
  localparam int RW     = SqW + 2;         // normalized radius, Q.16
  localparam int CoefW  = 32;
  localparam int GW     = 64;
  localparam int MagW   = 63;
  localparam int OutW   = 24;
  localparam int RndSh  = 29 - OutFracBits;
  localparam int AbsW   = OffW - 1;

  localparam logic [MagW-1:0]      Lim62  = MagW'(64'h4000_0000_0000_0000);
  localparam logic signed [GW:0]   Lim65  = 65'sh0_4000_0000_0000_0000;

  localparam logic [2:0] CfgWidth   = 3'd0;
  localparam logic [2:0] CfgHeight  = 3'd1;
  localparam logic [2:0] CfgDiamond = 3'd2;
  localparam logic [2:0] CfgLinear  = 3'd3;
  localparam logic [2:0] CfgSquare  = 3'd4;
  localparam logic [2:0] CfgCube    = 3'd5;
  localparam logic [2:0] CfgFourth  = 3'd6;

  typedef struct packed {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic                   in_region;
    logic signed [OutW-1:0] source_x;
    logic signed [OutW-1:0] source_y;
    logic                   saturated;
  } out_word_t;

  // pixel context riding along the pipeline
  typedef struct packed {
    logic                   vld;
    logic                   region;
    logic signed [OffW-1:0] x;
    logic signed [OffW-1:0] y;
    logic [RW-1:0]          r;
  } tag_t;

endpackage

FILE: src/rdm_front.sv
// ----------------------------------------------------------------------------
// rdm_front
// Input register, centre offsets, diamond test and squared radius.
// ----------------------------------------------------------------------------
module rdm_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         valid_i,
  input  rdm_pkg::in_word_t            word_i,
  input  logic [rdm_pkg::SideW-1:0]    w_i,
  input  logic [rdm_pkg::SideW-1:0]    h_i,
  input  logic                         diamond_i,
  output rdm_pkg::tag_t                tag_o,
  output logic [rdm_pkg::R2W-1:0]      r2_o
);

  logic              v0_q;
  rdm_pkg::in_word_t w0_q;
  rdm_pkg::tag_t     t1_q, t1_d, t2_q;
  logic [rdm_pkg::R2W-1:0] r2_q, r2_d;

  logic signed [16:0] c, rw, ws, hs, sum;
  logic               in_diamond;
  logic signed [31:0] xx, yy;

  always_comb begin
    c   = $signed({4'b0, w0_q.column});
    rw  = $signed({4'b0, w0_q.row});
    ws  = $signed({3'b0, w_i});
    hs  = $signed({3'b0, h_i});
    sum = c + rw;
    in_diamond = (sum >= ws - 17'sd1) && (c + ws + 17'sd1 > rw) &&
                 (sum < ws + 17'sd2 * hs - 17'sd1) && (rw + ws > c);
    t1_d.vld    = v0_q;
    t1_d.region = !diamond_i || in_diamond;
    t1_d.x      = rdm_pkg::OffW'(17'sd2 * c + 17'sd1 - ws);
    t1_d.y      = rdm_pkg::OffW'(17'sd2 * rw + 17'sd1 - hs);
    t1_d.r      = '0;
    xx   = t1_q.x * t1_q.x;
    yy   = t1_q.y * t1_q.y;
    r2_d = rdm_pkg::R2W'(xx + yy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      t1_q.vld <= 1'b0;
      t2_q.vld <= 1'b0;
    end else if (adv_i) begin
      v0_q <= valid_i;
      w0_q <= word_i;
      t1_q <= t1_d;
      t2_q <= t1_q;
      r2_q <= r2_d;
    end
  end

  assign tag_o = t2_q;
  assign r2_o  = r2_q;

endmodule

FILE: src/rdm_sqrt.sv
// ----------------------------------------------------------------------------
// rdm_sqrt
// Pipelined integer square root of r2 * 2^28, one result bit per stage.
// ----------------------------------------------------------------------------
module rdm_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  rdm_pkg::tag_t              tag_i,
  input  logic [rdm_pkg::R2W-1:0]    r2_i,
  output rdm_pkg::tag_t              tag_o,
  output logic [rdm_pkg::SqW-1:0]    sq_o
);

  localparam int N = rdm_pkg::SqW;

  rdm_pkg::tag_t                 tag_q [N+1];
  logic [rdm_pkg::SqInW-1:0]     v_q   [N+1];
  logic [rdm_pkg::RemW-1:0]      rem_q [N+1];
  logic [N-1:0]                  q_q   [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0].vld <= 1'b0;
    end else if (adv_i) begin
      tag_q[0] <= tag_i;
      v_q[0]   <= rdm_pkg::SqInW'({r2_i, {rdm_pkg::SqFrac{1'b0}}});
      rem_q[0] <= '0;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int I = N - 1 - k;
    logic [rdm_pkg::RemW-1:0] sh, trial;
    logic                     ge;
    assign sh    = {rem_q[k][rdm_pkg::RemW-3:0], v_q[k][2*I+1 -: 2]};
    assign trial = {1'b0, q_q[k], 2'b01};
    assign ge    = sh >= trial;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1].vld <= 1'b0;
      end else if (adv_i) begin
        tag_q[k+1] <= tag_q[k];
        v_q[k+1]   <= v_q[k];
        rem_q[k+1] <= ge ? sh - trial : sh;
        q_q[k+1]   <= {q_q[k][N-2:0], ge};
      end
    end
  end

  assign tag_o = tag_q[N];
  assign sq_o  = q_q[N];

endmodule

FILE: src/rdm_div.sv
// ----------------------------------------------------------------------------
// rdm_div
// Pipelined restoring divide of the scaled root by the shorter side.
// ----------------------------------------------------------------------------
module rdm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  rdm_pkg::tag_t              tag_i,
  input  logic [rdm_pkg::SqW-1:0]    sq_i,
  input  logic [rdm_pkg::SideW-1:0]  s_i,
  output rdm_pkg::tag_t              tag_o
);

  localparam int N = rdm_pkg::RW;
  localparam int DW = rdm_pkg::SideW;

  rdm_pkg::tag_t   tag_q [N+1];
  logic [N-1:0]    n_q   [N+1];
  logic [DW-1:0]   rem_q [N+1];
  logic [N-1:0]    q_q   [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0].vld <= 1'b0;
    end else if (adv_i) begin
      tag_q[0] <= tag_i;
      n_q[0]   <= {sq_i, 2'b00};
      rem_q[0] <= '0;
      q_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int I = N - 1 - k;
    logic [DW:0] sh, dif;
    logic        ge;
    assign sh  = {rem_q[k], n_q[k][I]};
    assign dif = sh - {1'b0, s_i};
    assign ge  = sh >= {1'b0, s_i};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1].vld <= 1'b0;
      end else if (adv_i) begin
        tag_q[k+1] <= tag_q[k];
        n_q[k+1]   <= n_q[k];
        rem_q[k+1] <= ge ? dif[DW-1:0] : sh[DW-1:0];
        q_q[k+1]   <= {q_q[k][N-2:0], ge};
      end
    end
  end

  always_comb begin
    tag_o   = tag_q[N];
    tag_o.r = q_q[N];
  end

endmodule

FILE: src/rdm_horner.sv
// ----------------------------------------------------------------------------
// rdm_horner
// One Horner step: g = clamp(coef + (t * r >> 16)), six register stages.
// ----------------------------------------------------------------------------
module rdm_horner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  rdm_pkg::tag_t                     tag_i,
  input  logic signed [rdm_pkg::GW-1:0]     t_i,
  input  logic signed [rdm_pkg::CoefW-1:0]  coef_i,
  output rdm_pkg::tag_t                     tag_o,
  output logic signed [rdm_pkg::GW-1:0]     g_o
);

  localparam int MW = rdm_pkg::MagW;
  localparam int PW = MW + rdm_pkg::RW;

  rdm_pkg::tag_t ta_q, tb_q, tc_q, td_q, te_q, tf_q;
  logic [3:0]    neg_q;                 // sign rides stages a..d
  logic [MW-1:0] mag_a_q, mag_d_q;
  logic [62:0]   pl_q;
  logic [61:0]   ph_q;
  logic [PW-1:0] p_q;
  logic signed [rdm_pkg::GW:0]   sum_q;
  logic signed [rdm_pkg::GW-1:0] g_q;

  logic [rdm_pkg::GW-1:0]   neg_t;
  logic [PW-17:0]           shv;
  logic signed [rdm_pkg::GW:0] mag_s, g_w;

  always_comb begin
    neg_t = rdm_pkg::GW'(-t_i);
    shv   = p_q[PW-1:16];
    mag_s = neg_q[3] ? -$signed({2'b0, mag_d_q}) : $signed({2'b0, mag_d_q});
    if (sum_q > rdm_pkg::Lim65)       g_w = rdm_pkg::Lim65;
    else if (sum_q < -rdm_pkg::Lim65) g_w = -rdm_pkg::Lim65;
    else                              g_w = sum_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q.vld <= 1'b0;
      tb_q.vld <= 1'b0;
      tc_q.vld <= 1'b0;
      td_q.vld <= 1'b0;
      te_q.vld <= 1'b0;
      tf_q.vld <= 1'b0;
    end else if (adv_i) begin
      ta_q     <= tag_i;
      neg_q[0] <= t_i[rdm_pkg::GW-1];
      mag_a_q  <= t_i[rdm_pkg::GW-1] ? neg_t[MW-1:0] : t_i[MW-1:0];
      tb_q     <= ta_q;
      neg_q[1] <= neg_q[0];
      pl_q     <= mag_a_q[31:0] * ta_q.r;
      ph_q     <= mag_a_q[MW-1:32] * ta_q.r;
      tc_q     <= tb_q;
      neg_q[2] <= neg_q[1];
      p_q      <= {ph_q, 32'b0} + PW'(pl_q);
      td_q     <= tc_q;
      neg_q[3] <= neg_q[2];
      mag_d_q  <= (shv > (PW-16)'(rdm_pkg::Lim62)) ? rdm_pkg::Lim62 : shv[MW-1:0];
      te_q     <= td_q;
      sum_q    <= $signed({{(rdm_pkg::GW+1-rdm_pkg::CoefW){coef_i[rdm_pkg::CoefW-1]}},
                           coef_i}) + mag_s;
      tf_q     <= te_q;
      g_q      <= g_w[rdm_pkg::GW-1:0];
    end
  end

  assign tag_o = tf_q;
  assign g_o   = g_q;

endmodule

FILE: src/rdm_coord.sv
// ----------------------------------------------------------------------------
// rdm_coord
// Scales both offsets by the gain, recentres, rounds and saturates.
// ----------------------------------------------------------------------------
module rdm_coord (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  rdm_pkg::tag_t                  tag_i,
  input  logic signed [rdm_pkg::GW-1:0]  g_i,
  input  logic [rdm_pkg::SideW-1:0]      w_i,
  input  logic [rdm_pkg::SideW-1:0]      h_i,
  output logic                           valid_o,
  output rdm_pkg::out_word_t             word_o
);

  localparam int MW = rdm_pkg::MagW;
  localparam int AW = rdm_pkg::AbsW;
  localparam int PW = MW + AW;
  localparam int VW = rdm_pkg::GW + 1 - rdm_pkg::RndSh;
  localparam logic signed [rdm_pkg::GW:0] Rnd = 65'sd1 <<< (rdm_pkg::RndSh - 1);
  localparam logic signed [VW-1:0] OMax = VW'((64'sd1 <<< (rdm_pkg::OutW - 1)) - 1);
  localparam logic signed [VW-1:0] OMin = -VW'(64'sd1 <<< (rdm_pkg::OutW - 1));

  logic [4:0] va_q;
  logic [4:0] reg_q;
  logic [1:0] nx_q [4];                 // product sign of x / y, stages a..d
  logic [MW-1:0] gm_q;
  logic [AW-1:0] xm_q, ym_q;
  logic [31+AW:0] xl_q, yl_q;
  logic [30+AW:0] xh_q, yh_q;
  logic [PW-1:0]  xp_q, yp_q;
  logic [MW-1:0]  xmg_q, ymg_q;
  logic signed [rdm_pkg::GW:0] xn_q, yn_q;
  logic               vo_q;
  rdm_pkg::out_word_t wo_q;

  logic [rdm_pkg::GW-1:0] gneg;
  logic [rdm_pkg::OffW-1:0] xneg, yneg;
  logic signed [rdm_pkg::GW:0] xs, ys, wsh, hsh;
  logic signed [VW-1:0] xv, yv;
  logic signed [rdm_pkg::OutW-1:0] xo, yo;
  logic sat;

  always_comb begin
    gneg = rdm_pkg::GW'(-g_i);
    xneg = rdm_pkg::OffW'(-tag_i.x);
    yneg = rdm_pkg::OffW'(-tag_i.y);
    xs = nx_q[3][0] ? -$signed({2'b0, xmg_q}) : $signed({2'b0, xmg_q});
    ys = nx_q[3][1] ? -$signed({2'b0, ymg_q}) : $signed({2'b0, ymg_q});
    wsh = $signed({(rdm_pkg::GW + 1 - rdm_pkg::SideW - 28)'(0), w_i, 28'b0});
    hsh = $signed({(rdm_pkg::GW + 1 - rdm_pkg::SideW - 28)'(0), h_i, 28'b0});
    xv = xn_q[rdm_pkg::GW:rdm_pkg::RndSh];
    yv = yn_q[rdm_pkg::GW:rdm_pkg::RndSh];
    sat = 1'b0;
    if (xv > OMax) begin xo = OMax[rdm_pkg::OutW-1:0]; sat = 1'b1; end
    else if (xv < OMin) begin xo = OMin[rdm_pkg::OutW-1:0]; sat = 1'b1; end
    else xo = xv[rdm_pkg::OutW-1:0];
    if (yv > OMax) begin yo = OMax[rdm_pkg::OutW-1:0]; sat = 1'b1; end
    else if (yv < OMin) begin yo = OMin[rdm_pkg::OutW-1:0]; sat = 1'b1; end
    else yo = yv[rdm_pkg::OutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= '0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      va_q  <= {va_q[3:0], tag_i.vld};
      reg_q <= {reg_q[3:0], tag_i.region};
      // stage a: magnitudes
      gm_q  <= g_i[rdm_pkg::GW-1] ? gneg[MW-1:0] : g_i[MW-1:0];
      xm_q  <= tag_i.x[rdm_pkg::OffW-1] ? xneg[AW-1:0] : tag_i.x[AW-1:0];
      ym_q  <= tag_i.y[rdm_pkg::OffW-1] ? yneg[AW-1:0] : tag_i.y[AW-1:0];
      nx_q[0] <= {g_i[rdm_pkg::GW-1] ^ tag_i.y[rdm_pkg::OffW-1],
                  g_i[rdm_pkg::GW-1] ^ tag_i.x[rdm_pkg::OffW-1]};
      // stage b: partial products
      xl_q <= gm_q[31:0] * xm_q;
      xh_q <= gm_q[MW-1:32] * xm_q;
      yl_q <= gm_q[31:0] * ym_q;
      yh_q <= gm_q[MW-1:32] * ym_q;
      nx_q[1] <= nx_q[0];
      // stage c: combine
      xp_q <= {xh_q, 32'b0} + PW'(xl_q);
      yp_q <= {yh_q, 32'b0} + PW'(yl_q);
      nx_q[2] <= nx_q[1];
      // stage d: clamp magnitude
      xmg_q <= (xp_q > PW'(rdm_pkg::Lim62)) ? rdm_pkg::Lim62 : xp_q[MW-1:0];
      ymg_q <= (yp_q > PW'(rdm_pkg::Lim62)) ? rdm_pkg::Lim62 : yp_q[MW-1:0];
      nx_q[3] <= nx_q[2];
      // stage e: recentre and add rounding
      xn_q <= xs + wsh + Rnd;
      yn_q <= ys + hsh + Rnd;
      // stage f: round, saturate, zero the word of pixels outside the region
      vo_q <= va_q[4];
      if (reg_q[4]) begin
        wo_q.in_region <= 1'b1;
        wo_q.source_x  <= xo;
        wo_q.source_y  <= yo;
        wo_q.saturated <= sat;
      end else begin
        wo_q <= '0;
      end
    end
  end

  assign valid_o = vo_q;
  assign word_o  = wo_q;

endmodule

FILE: src/radial_distortion_map_generator_unit.sv
// ----------------------------------------------------------------------------
// radial_distortion_map_generator_unit
// Radial lens-distortion source coordinate generator, one pixel per clock.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one result word per pixel,
// in order; each pixel passes through 91 register stages, and a new pixel
// is taken every cycle while the output is not stalled.
// The stages are three front stages, the square root (an input register
// and one result bit per stage, 30 stages) and the divide by the shorter
// side (an input register and one quotient bit per stage, 32 stages),
// followed by three six-stage Horner steps and a six-stage coordinate
// stage. A stall on the output freezes the whole pipeline.
// Configuration registers may be written only while no pixel is in flight.
module radial_distortion_map_generator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rdm_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rdm_pkg::out_word_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int SW = rdm_pkg::SideW;

  logic [SW-1:0] width_q, height_q;
  logic          diamond_q;
  logic signed [rdm_pkg::CoefW-1:0] lin_q, sq_q, cube_q, four_q;

  logic [SW-1:0] w, h, s;
  logic          adv;

  rdm_pkg::tag_t t_front, t_sqrt, t_div, t_h1, t_h2, t_h3;
  logic [rdm_pkg::R2W-1:0] r2;
  logic [rdm_pkg::SqW-1:0] root;
  logic signed [rdm_pkg::GW-1:0] g1, g2, g3, g0;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SW'(1024);
      height_q  <= SW'(1024);
      diamond_q <= 1'b0;
      lin_q     <= 32'sh1000_0000;
      sq_q      <= '0;
      cube_q    <= '0;
      four_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rdm_pkg::CfgWidth:   width_q   <= cfg_data_i[SW-1:0];
        rdm_pkg::CfgHeight:  height_q  <= cfg_data_i[SW-1:0];
        rdm_pkg::CfgDiamond: diamond_q <= cfg_data_i[0];
        rdm_pkg::CfgLinear:  lin_q     <= cfg_data_i;
        rdm_pkg::CfgSquare:  sq_q      <= cfg_data_i;
        rdm_pkg::CfgCube:    cube_q    <= cfg_data_i;
        rdm_pkg::CfgFourth:  four_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp sides to [1, MaxDim]
  always_comb begin
    if (width_q == '0) w = SW'(1);
    else if (width_q > SW'(rdm_pkg::MaxDim)) w = SW'(rdm_pkg::MaxDim);
    else w = width_q;
    if (height_q == '0) h = SW'(1);
    else if (height_q > SW'(rdm_pkg::MaxDim)) h = SW'(rdm_pkg::MaxDim);
    else h = height_q;
    s = (w < h) ? w : h;
  end

  // hold every stage while the output word waits
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign g0         = rdm_pkg::GW'(four_q);

  rdm_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i), .word_i(in_data_i),
    .w_i(w), .h_i(h), .diamond_i(diamond_q), .tag_o(t_front), .r2_o(r2)
  );

  rdm_sqrt u_sqrt (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_front), .r2_i(r2),
    .tag_o(t_sqrt), .sq_o(root)
  );

  rdm_div u_div (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_sqrt), .sq_i(root), .s_i(s),
    .tag_o(t_div)
  );

  rdm_horner u_h1 (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_div), .t_i(g0), .coef_i(cube_q),
    .tag_o(t_h1), .g_o(g1)
  );

  rdm_horner u_h2 (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_h1), .t_i(g1), .coef_i(sq_q),
    .tag_o(t_h2), .g_o(g2)
  );

  rdm_horner u_h3 (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_h2), .t_i(g2), .coef_i(lin_q),
    .tag_o(t_h3), .g_o(g3)
  );

  rdm_coord u_coord (
    .clk_i, .rst_ni, .adv_i(adv), .tag_i(t_h3), .g_i(g3), .w_i(w), .h_i(h),
    .valid_o(out_valid_o), .word_o(out_data_o)
  );

endmodule

FILE: tb/sv/radial_distortion_map_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// radial_distortion_map_generator_unit_tb
// Self-checking bench for the radial distortion source coordinate generator.
// ----------------------------------------------------------------------------
// Pixel words are pushed through the block under several register settings.
// A fixed-point predictor computes each expected result word as the pixel is
// accepted. Results are compared field by field, in order. Both channels
// idle at random, except in one long quiet window where they do not idle.
// ----------------------------------------------------------------------------
module radial_distortion_map_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int DrainWait  = 120;
  localparam longint Lim    = 64'sh4000_0000_0000_0000;

  class remap_scoreboard;
    longint unsigned    img_w, img_h;
    bit                 diamond;
    longint             ca, cb, cc, cd;
    rdm_pkg::out_word_t expected_q[$];
    int                 errors;

    function new();
      img_w = 1024; img_h = 1024; diamond = 0;
      ca = 268435456; cb = 0; cc = 0; cd = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        rdm_pkg::CfgWidth:   img_w = val[13:0];
        rdm_pkg::CfgHeight:  img_h = val[13:0];
        rdm_pkg::CfgDiamond: diamond = val[0];
        rdm_pkg::CfgLinear:  ca = longint'(signed'(val));
        rdm_pkg::CfgSquare:  cb = longint'(signed'(val));
        rdm_pkg::CfgCube:    cc = longint'(signed'(val));
        rdm_pkg::CfgFourth:  cd = longint'(signed'(val));
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // product shifted right, truncated toward zero, clipped to +-2^62
    function longint scaled_mul(longint a, longint b, int sh);
      bit           neg;
      logic [127:0] ma, mb, p;
      longint       mag;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? 128'(-a) : 128'(a);
      mb = (b < 0) ? 128'(-b) : 128'(b);
      p = (ma * mb) >> sh;
      mag = (p > 128'(Lim)) ? Lim : longint'(p[63:0]);
      return neg ? -mag : mag;
    endfunction

    function longint clip62(longint v);
      if (v > Lim) return Lim;
      if (v < -Lim) return -Lim;
      return v;
    endfunction

    function longint side_of(longint unsigned v);
      if (v < 1) return 1;
      if (v > rdm_pkg::MaxDim) return rdm_pkg::MaxDim;
      return longint'(v);
    endfunction

    function longint to_coord(longint off, longint g, longint side, inout bit sat);
      longint num, v;
      num = scaled_mul(off, g, 0) + side * (64'sd1 << 28);
      v = (num + (64'sd1 << (rdm_pkg::RndSh - 1))) >>> rdm_pkg::RndSh;
      if (v > 8388607) begin sat = 1; return 8388607; end
      if (v < -8388608) begin sat = 1; return -8388608; end
      return v;
    endfunction

    function rdm_pkg::out_word_t remap(rdm_pkg::in_word_t px);
      longint             col, row, w, h, s, x, y, r, g, sx, sy;
      longint unsigned    r2;
      bit                 sat;
      rdm_pkg::out_word_t o;
      o = '0;
      col = px.column; row = px.row;
      w = side_of(img_w); h = side_of(img_h);
      s = (w < h) ? w : h;
      sat = 0;
      if (diamond && !(row + col >= w - 1 && col > row - w - 1 &&
                       row + col < w + 2 * h - 1 && row > col - w))
        return o;
      x = 2 * col + 1 - w;
      y = 2 * row + 1 - h;
      r2 = longint'(x * x) + longint'(y * y);
      r = longint'((int_sqrt(r2 << 28) << 2) / longint'(s));
      g = cd;
      g = clip62(cc + scaled_mul(g, r, 16));
      g = clip62(cb + scaled_mul(g, r, 16));
      g = clip62(ca + scaled_mul(g, r, 16));
      sx = to_coord(x, g, w, sat);
      sy = to_coord(y, g, h, sat);
      o.in_region = 1;
      o.source_x = sx[rdm_pkg::OutW-1:0];
      o.source_y = sy[rdm_pkg::OutW-1:0];
      o.saturated = sat;
      return o;
    endfunction

    function void note_pixel(rdm_pkg::in_word_t px);
      expected_q.push_back(remap(px));
    endfunction

    function void check_result(rdm_pkg::out_word_t got);
      rdm_pkg::out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.in_region !== got.in_region) begin
        $display("%0t: in_region exp %0d got %0d", $realtime, e.in_region, got.in_region);
        errors++;
      end
      if (e.source_x !== got.source_x) begin
        $display("%0t: source_x exp %0d got %0d", $realtime, e.source_x, got.source_x);
        errors++;
      end
      if (e.source_y !== got.source_y) begin
        $display("%0t: source_y exp %0d got %0d", $realtime, e.source_y, got.source_y);
        errors++;
      end
      if (e.saturated !== got.saturated) begin
        $display("%0t: saturated exp %0d got %0d", $realtime, e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  rdm_pkg::in_word_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  rdm_pkg::out_word_t out_data_o;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;

  remap_scoreboard sb = new();
  int cycles = 0;

  radial_distortion_map_generator_unit u_dut (.*);

  always #2 clk_i = ~clk_i;

  // long stretch without idling on either side
  function bit quiet();
    return cycles > 3000 && cycles < 6000;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet() && ($urandom_range(99) < 15);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // leave valid up so that writes follow back to back; set_all drops it
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic send_pixel(logic [12:0] col, logic [12:0] row);
    rdm_pkg::in_word_t px;
    px.column = col;
    px.row = row;
    in_valid_i <= 1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_pixel(px);
    // idle before the next word, keep valid up otherwise
    if (!quiet() && $urandom_range(99) < 15) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(int n);
    int w, h;
    w = int'(sb.side_of(sb.img_w));
    h = int'(sb.side_of(sb.img_h));
    repeat (n) begin
      if (sb.diamond || $urandom_range(9) == 0)
        send_pixel(13'($urandom_range(8191)), 13'($urandom_range(8191)));
      else
        send_pixel(13'($urandom_range(w - 1)), 13'($urandom_range(h - 1)));
    end
    in_valid_i <= 0;
    drain();
  endtask

  task automatic set_all(logic [31:0] w, logic [31:0] h, logic [31:0] dm,
                         logic [31:0] a, logic [31:0] b, logic [31:0] c,
                         logic [31:0] d);
    write_reg(rdm_pkg::CfgWidth, w);
    write_reg(rdm_pkg::CfgHeight, h);
    write_reg(rdm_pkg::CfgDiamond, dm);
    write_reg(rdm_pkg::CfgLinear, a);
    write_reg(rdm_pkg::CfgSquare, b);
    write_reg(rdm_pkg::CfgCube, c);
    write_reg(rdm_pkg::CfgFourth, d);
    cfg_valid_i <= 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset settings: corners, centre, outside the image
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(511, 512);
    send_pixel(512, 511);
    send_pixel(8191, 0);
    send_pixel(0, 8191);
    send_pixel(8191, 8191);
    send_pixel(4096, 2048);
    in_valid_i <= 0;
    drain();

    // odd sides give an exact centre pixel, diamond on
    set_all(5, 3, 1, 32'h1000_0000, 32'h0200_0000, 32'hFF00_0000, 32'h0010_0000);
    send_pixel(2, 1);
    send_pixel(0, 0);
    send_pixel(4, 2);
    send_pixel(1, 0);
    send_pixel(2, 0);
    send_pixel(4, 4);
    send_pixel(8191, 8191);
    in_valid_i <= 0;
    drain();

    // out of range index is ignored; zero and oversized sides clamp
    write_reg(3'd7, 32'hFFFF_FFFF);
    set_all(0, 16383, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(0, 0);
    send_pixel(0, 8191);
    send_pixel(8191, 4096);
    in_valid_i <= 0;
    drain();
    set_all(16383, 1, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pixel(0, 0);
    send_pixel(8191, 0);
    send_pixel(4096, 8191);
    in_valid_i <= 0;
    drain();

    set_all(1024, 1024, 0, 32'h1000_0000, 0, 0, 0);
    run_random(110);
    set_all(640, 480, 0, 32'h0F00_0000, 32'h0080_0000, 32'hFFC0_0000, 32'h0004_0000);
    run_random(110);
    set_all(1, 8192, 0, $urandom, $urandom, $urandom, $urandom);
    run_random(100);
    set_all(1024, 512, 1, 32'h1100_0000, 32'hFF00_0000, 32'h0040_0000, 32'h0);
    run_random(110);
    set_all(8192, 8192, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    run_random(100);
    set_all(8192, 3, 1, $urandom, $urandom, $urandom, $urandom);
    run_random(100);
    set_all($urandom_range(1, 8192), $urandom_range(1, 8192), 0,
            $urandom, $urandom, $urandom, $urandom);
    run_random(110);
    set_all(7, 9, 1, 32'h1000_0000, 32'h0100_0000, 32'h0, 32'hFFF0_0000);
    run_random(100);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
